/* hw/rtl/oat_pkg.sv */
// Package for the ordered array table: sizes, field widths, codes and shared types.
package oat_pkg;

  localparam int CAPACITY  = 1024;
  localparam int WORD_BITS = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam int ACTION_W = 3;
  localparam int POS_W    = 11;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [ACTION_W-1:0] {
    ACT_READ   = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_INSERT = 3'd2,
    ACT_MODIFY = 3'd3,
    ACT_DELETE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Outcome of the request check.
  typedef struct packed {
    status_t status;
    logic    at_end;
  } chk_t;

endpackage

/* hw/rtl/oat_if.sv */
// Request and response channel interfaces of the ordered array table.
interface oat_req_if import oat_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [POS_W-1:0]           position;
  logic signed [DATA_W-1:0]   new_value;

  modport source (output valid, action, position, new_value, input ready);
  modport sink   (input valid, action, position, new_value, output ready);
endinterface

interface oat_rsp_if import oat_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   data_out;
  logic [1:0]                 status;
  logic [COUNT_W-1:0]         entries_used;

  modport source (output valid, data_out, status, entries_used, input ready);
  modport sink   (input valid, data_out, status, entries_used, output ready);
endinterface

/* hw/rtl/oat_check.sv */
// Request check: range and capacity tests that give the status of a request.
module oat_check import oat_pkg::*; (
  input  logic [ACTION_W-1:0] action,
  input  logic [POS_W-1:0]    position,
  input  logic [CNT_W-1:0]    count,
  output chk_t                chk
);

  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic             below;
  logic             full;

  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(count);
  assign below   = pos_ext < cnt_ext;
  assign full    = cnt_ext >= CMP_W'(CAPACITY);

  always_comb begin
    chk.at_end = (pos_ext == cnt_ext);
    case (action)
      ACT_READ, ACT_MODIFY, ACT_DELETE: chk.status = below ? ST_OK : ST_RANGE;
      ACT_APPEND: chk.status = full ? ST_FULL : ST_OK;
      ACT_INSERT: begin
        // The index test takes precedence over the full test.
        if (pos_ext > cnt_ext) chk.status = ST_RANGE;
        else if (full)         chk.status = ST_FULL;
        else                   chk.status = ST_OK;
      end
      default: chk.status = ST_RANGE;
    endcase
  end

endmodule

/* hw/rtl/ordered_array_table_core.sv */
// Top level of the ordered array table: element memory, shift sequencer and result register.
//
// The block holds an ordered array of up to CAPACITY words in one synchronous memory
// (one write and one read per cycle, registered read data) and a count of the entries
// in use. Each request item reads, appends, inserts, modifies or deletes, and returns one
// result item with the read, old or removed value (else zero), a status and the count
// after the request. One request is worked on at a time. Append and an insert at the end
// of the array move no entries. Every entry that moves costs one memory read and one
// memory write, streamed one entry per cycle through the single read port, and delete
// also reads the removed entry itself. The worst case is a delete at index zero from a
// full store. A rejected request changes nothing and goes straight to the result state.
// Once a result is loaded, the block goes back to idle. The result sits in an output
// register, so a finished result may wait on the response channel while the block is
// already back in idle and taking the next request item. The memory has no reset: only
// entries below the count are ever read, and those have always been written.
module ordered_array_table_core import oat_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  oat_req_if.sink     req,
  oat_rsp_if.source   rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FINAL,
    S_RESULT
  } state_t;

  state_t                state;
  logic [ACTION_W-1:0]   op;
  logic [IDX_W-1:0]      pos_r;
  logic [WORD_BITS-1:0]  val_r;
  logic [WORD_BITS-1:0]  data_r;
  status_t               stat_r;
  logic [CNT_W-1:0]      cnt;
  logic [IDX_W-1:0]      ra;
  logic [IDX_W-1:0]      last;
  logic [IDX_W-1:0]      ra_q;
  logic                  issuing;
  logic                  rv;

  logic                  out_valid;
  logic [DATA_W-1:0]     out_data;
  status_t               out_status;
  logic [COUNT_W-1:0]    out_count;

  // Element memory and its ports.
  logic [WORD_BITS-1:0]  mem [CAPACITY];
  logic [WORD_BITS-1:0]  rdata;
  logic                  we;
  logic [IDX_W-1:0]      wa;
  logic [WORD_BITS-1:0]  wd;
  logic                  re;

  chk_t                  chk;
  logic                  accept;
  logic [CNT_W-1:0]      cnt_dec;
  logic                  slot_free;
  logic                  first_del;

  oat_check u_check (
    .action   (req.action),
    .position (req.position),
    .count    (cnt),
    .chk      (chk)
  );

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign cnt_dec   = cnt - CNT_W'(1);
  assign slot_free = !out_valid || rsp.ready;
  // The first word read by a delete is the removed entry itself.
  assign first_del = (ra_q == pos_r);

  assign rsp.valid        = out_valid;
  assign rsp.data_out     = out_data;
  assign rsp.status       = out_status;
  assign rsp.entries_used = out_count;

  // Memory port control. Reads stream at ra; each word that comes back is written one
  // place up (insert) or one place down (delete), two addresses away from the read in
  // flight, so a read never meets a write to the same entry.
  always_comb begin
    re = (state == S_SCAN) && issuing;
    we = 1'b0;
    wa = pos_r;
    wd = val_r;
    case (state)
      S_SCAN: begin
        if (rv) begin
          if (op == ACT_INSERT) begin
            we = 1'b1;
            wa = ra_q + IDX_W'(1);
            wd = rdata;
          end else if (op == ACT_DELETE && !first_del) begin
            we = 1'b1;
            wa = ra_q - IDX_W'(1);
            wd = rdata;
          end
        end
      end
      S_FINAL: begin
        we = (op == ACT_APPEND) || (op == ACT_INSERT) || (op == ACT_MODIFY);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re) rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      issuing   <= 1'b0;
      rv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // While a result is being loaded the register is refilled, so it is only
      // emptied in the other states.
      if (out_valid && rsp.ready && state != S_RESULT) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= req.action;
            pos_r  <= IDX_W'(req.position);
            val_r  <= WORD_BITS'($unsigned(req.new_value));
            data_r <= '0;
            stat_r <= chk.status;
            rv     <= 1'b0;
            if (chk.status != ST_OK) begin
              state <= S_RESULT;
            end else begin
              case (req.action)
                ACT_READ, ACT_MODIFY: begin
                  ra      <= IDX_W'(req.position);
                  last    <= IDX_W'(req.position);
                  issuing <= 1'b1;
                  state   <= S_SCAN;
                end
                ACT_DELETE: begin
                  ra      <= IDX_W'(req.position);
                  last    <= cnt_dec[IDX_W-1:0];
                  issuing <= 1'b1;
                  state   <= S_SCAN;
                end
                ACT_INSERT: begin
                  if (chk.at_end) begin
                    state <= S_FINAL;
                  end else begin
                    ra      <= cnt_dec[IDX_W-1:0];
                    last    <= IDX_W'(req.position);
                    issuing <= 1'b1;
                    state   <= S_SCAN;
                  end
                end
                ACT_APPEND: begin
                  pos_r <= cnt[IDX_W-1:0];
                  state <= S_FINAL;
                end
                default: begin
                  state <= S_RESULT;
                end
              endcase
            end
          end
        end

        S_SCAN: begin
          rv   <= issuing;
          ra_q <= ra;
          if (issuing) begin
            if (ra == last) issuing <= 1'b0;
            else if (op == ACT_INSERT) ra <= ra - IDX_W'(1);
            else ra <= ra + IDX_W'(1);
          end
          if (rv) begin
            if (op == ACT_READ || op == ACT_MODIFY || (op == ACT_DELETE && first_del)) begin
              data_r <= rdata;
            end
          end
          if (!issuing && !rv) state <= S_FINAL;
        end

        S_FINAL: begin
          if (op == ACT_APPEND || op == ACT_INSERT) cnt <= cnt + CNT_W'(1);
          else if (op == ACT_DELETE) cnt <= cnt_dec;
          state <= S_RESULT;
        end

        S_RESULT: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            out_data   <= DATA_W'(data_r);
            out_status <= stat_r;
            out_count  <= COUNT_W'(cnt);
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
